>>> hdl/tscv_pkg.sv
// Shared types and constants for the touch sample calibration block.
`timescale 1ns / 1ps
package tscv_pkg;

  localparam int unsigned RAW_COORD_BITS_DEF = 10;
  localparam int unsigned COEF_W = 32;
  localparam int unsigned DIV_W = 31;
  localparam int unsigned GAP_W = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned VIEW_W = 2;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_COEF_A = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF_B = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_C = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEF_D = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COEF_E = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_COEF_F = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DIVISOR = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_GAP = 3'd7;

  localparam logic [VIEW_W-1:0] VIEW_STARTUP = 2'd0;
  localparam logic [VIEW_W-1:0] VIEW_LOADING = 2'd1;
  localparam logic [VIEW_W-1:0] VIEW_MAIN = 2'd2;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
    logic signed [COEF_W-1:0] coef_d;
    logic signed [COEF_W-1:0] coef_e;
    logic signed [COEF_W-1:0] coef_f;
    logic [DIV_W-1:0]         cal_divisor;
    logic [GAP_W-1:0]         sample_gap_ms;
  } cfg_t;

  typedef enum logic [2:0] {
    LP_IDLE,
    LP_MAC,
    LP_OFF,
    LP_ABS,
    LP_DIV
  } lane_phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_LOAD
  } top_state_e;

endpackage

>>> hdl/touch_sample_calibrate_and_view_step_top.sv
// Top level of the touch poll block: poll qualification, calibration lanes and view cycle.
//
// Usage: each transfer on the s_axis channel is one touch poll, packed in
// tdata as now_ms, panel_touched, raw_x and raw_y from the lowest bit up.
// Each poll yields exactly one transfer on the m_axis channel carrying the
// held calibrated coordinates, the sample and edge flags and the view index.
// Registers are to be written over the APB port only while the block is idle;
// the block itself does not enforce this. A poll that does not take a new
// sample goes from acceptance into the load state and then into the output
// register, and the block is ready for the next poll in the same cycle that
// this result appears. A poll that takes a sample runs both coordinates
// through bit-serial lanes: shift-and-add over the RAW_COORD_BITS bits of
// each reading, an offset step and a sign step, then the restoring divider
// over the 34 + RAW_COORD_BITS bit sum, one bit per cycle, and then through
// the done register and the load state into the output register. One poll
// is worked on at a time.
// The result sits in an output register; while the receiver stalls, the block
// finishes the next poll and then waits for that register to drain.
// Reset clears the held state, the view and the registers to their defaults;
// the block accepts a poll in the first cycle after reset is released.
`timescale 1ns / 1ps
module touch_sample_calibrate_and_view_step_top #(
  parameter int unsigned RAW_COORD_BITS = tscv_pkg::RAW_COORD_BITS_DEF,
  parameter int unsigned IN_DATA_W = ((2 * RAW_COORD_BITS + 33 + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tscv_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [tscv_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [tscv_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // now_ms, panel_touched, raw_x, raw_y, zero fill
  input  logic [IN_DATA_W-1:0]                s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // display_x, display_y, new_sample, pressed_now, press_edge,
  // release_edge, view_index
  output logic [tscv_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o
);

  localparam int unsigned TOUCH_POS = tscv_pkg::TIME_W;
  localparam int unsigned RX_LSB = TOUCH_POS + 1;
  localparam int unsigned RY_LSB = RX_LSB + RAW_COORD_BITS;

  tscv_pkg::cfg_t                 cfg;
  tscv_pkg::top_state_e           state_q, state_d;

  logic [tscv_pkg::TIME_W-1:0]    now_w;
  logic                           touched_w;
  logic [RAW_COORD_BITS-1:0]      rx_w, ry_w;
  logic [tscv_pkg::TIME_W-1:0]    elapsed;
  logic                           qual_w;
  logic                           accept;
  logic                           out_free;
  logic                           lane_start;
  logic                           load_en;
  logic                           ready;

  logic [tscv_pkg::TIME_W-1:0]    now_q;
  logic                           touched_q, qual_q;
  logic [tscv_pkg::TIME_W-1:0]    last_time_q;
  logic                           pressed_q;
  logic [tscv_pkg::VIEW_W-1:0]    view_q, view_d;
  logic [tscv_pkg::COORD_W-1:0]   held_x_q, held_y_q;
  logic                           m_valid_q;
  logic [tscv_pkg::OUT_DATA_W-1:0] m_data_q;

  logic                           x_done, y_done;
  logic [tscv_pkg::COORD_W-1:0]   x_res, y_res;

  logic                           fresh, new_pressed, down, up;
  logic [tscv_pkg::COORD_W-1:0]   x_next, y_next;

  tscv_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign now_w = s_axis_tdata_i[tscv_pkg::TIME_W-1:0];
  assign touched_w = s_axis_tdata_i[TOUCH_POS];
  assign rx_w = s_axis_tdata_i[RX_LSB +: RAW_COORD_BITS];
  assign ry_w = s_axis_tdata_i[RY_LSB +: RAW_COORD_BITS];
  assign elapsed = now_w - last_time_q;
  assign qual_w = elapsed > tscv_pkg::TIME_W'(cfg.sample_gap_ms);
  assign accept = s_axis_tvalid_i && ready;
  assign out_free = !m_valid_q || m_axis_tready_i;

  tscv_lane #(.RAW_BITS(RAW_COORD_BITS)) u_lane_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lane_start),
    .wx_i    (cfg.coef_a),
    .wy_i    (cfg.coef_b),
    .off_i   (cfg.coef_c),
    .rx_i    (rx_w),
    .ry_i    (ry_w),
    .div_i   (cfg.cal_divisor),
    .done_o  (x_done),
    .res_o   (x_res)
  );

  tscv_lane #(.RAW_BITS(RAW_COORD_BITS)) u_lane_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lane_start),
    .wx_i    (cfg.coef_d),
    .wy_i    (cfg.coef_e),
    .off_i   (cfg.coef_f),
    .rx_i    (rx_w),
    .ry_i    (ry_w),
    .div_i   (cfg.cal_divisor),
    .done_o  (y_done),
    .res_o   (y_res)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      tscv_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (qual_w && touched_w) ? tscv_pkg::ST_CALC : tscv_pkg::ST_LOAD;
        end
      end
      tscv_pkg::ST_CALC: if (x_done) state_d = tscv_pkg::ST_LOAD;
      tscv_pkg::ST_LOAD: if (out_free) state_d = tscv_pkg::ST_IDLE;
      default:           state_d = tscv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ready = 1'b0;
    lane_start = 1'b0;
    load_en = 1'b0;
    case (state_q)
      tscv_pkg::ST_IDLE: begin
        ready = 1'b1;
        lane_start = s_axis_tvalid_i && qual_w && touched_w;
      end
      tscv_pkg::ST_CALC: ready = 1'b0;
      tscv_pkg::ST_LOAD: load_en = out_free;
      default:           ready = 1'b0;
    endcase
  end

  assign s_axis_tready_o = ready;

  assign fresh = qual_q && touched_q;
  assign new_pressed = qual_q ? touched_q : pressed_q;
  assign down = new_pressed && !pressed_q;
  assign up = !new_pressed && pressed_q;
  assign x_next = fresh ? x_res : held_x_q;
  assign y_next = fresh ? y_res : held_y_q;

  always_comb begin
    view_d = view_q;
    if (up) begin
      case (view_q)
        tscv_pkg::VIEW_STARTUP: view_d = tscv_pkg::VIEW_LOADING;
        tscv_pkg::VIEW_LOADING: view_d = tscv_pkg::VIEW_MAIN;
        tscv_pkg::VIEW_MAIN:    view_d = tscv_pkg::VIEW_STARTUP;
        default:                view_d = view_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tscv_pkg::ST_IDLE;
      last_time_q <= '0;
      pressed_q <= 1'b0;
      view_q <= tscv_pkg::VIEW_STARTUP;
      held_x_q <= '0;
      held_y_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_en) begin
        pressed_q <= new_pressed;
        view_q <= view_d;
        held_x_q <= x_next;
        held_y_q <= y_next;
        if (fresh) begin
          last_time_q <= now_q;
        end
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q <= now_w;
      touched_q <= touched_w;
      qual_q <= qual_w;
    end
    if (load_en) begin
      m_data_q <= {2'b00, view_d, up, down, new_pressed, fresh, y_next, x_next};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o = m_data_q;

`ifndef SYNTHESIS
  a_lanes_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_done == y_done)
    else $error("calibration lanes finished in different cycles");

  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_done |-> state_q == tscv_pkg::ST_CALC)
    else $error("lane finished outside of a calculation");

  a_one_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("second poll accepted before the first was finished");

  a_view_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    view_q != 2'd3)
    else $error("view index left its cycle");

  a_edges_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_en |-> !(up && down))
    else $error("press and release reported for the same poll");
`endif

endmodule

>>> hdl/tscv_regs.sv
// APB configuration registers of the calibration block.
`timescale 1ns / 1ps
module tscv_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tscv_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [tscv_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [tscv_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output tscv_pkg::cfg_t                      cfg_o
);

  tscv_pkg::cfg_t                    cfg_q;
  tscv_pkg::cfg_t                    cfg_d;
  logic [tscv_pkg::REG_IDX_W-1:0]    idx;
  logic                              wr_en;

  assign pready = 1'b1;
  assign idx = paddr[tscv_pkg::APB_ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        tscv_pkg::REG_COEF_A:  cfg_d.coef_a = pwdata;
        tscv_pkg::REG_COEF_B:  cfg_d.coef_b = pwdata;
        tscv_pkg::REG_COEF_C:  cfg_d.coef_c = pwdata;
        tscv_pkg::REG_COEF_D:  cfg_d.coef_d = pwdata;
        tscv_pkg::REG_COEF_E:  cfg_d.coef_e = pwdata;
        tscv_pkg::REG_COEF_F:  cfg_d.coef_f = pwdata;
        tscv_pkg::REG_DIVISOR: cfg_d.cal_divisor = pwdata[tscv_pkg::DIV_W-1:0];
        tscv_pkg::REG_GAP:     cfg_d.sample_gap_ms = pwdata[tscv_pkg::GAP_W-1:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tscv_pkg::REG_COEF_A:  prdata = cfg_q.coef_a;
      tscv_pkg::REG_COEF_B:  prdata = cfg_q.coef_b;
      tscv_pkg::REG_COEF_C:  prdata = cfg_q.coef_c;
      tscv_pkg::REG_COEF_D:  prdata = cfg_q.coef_d;
      tscv_pkg::REG_COEF_E:  prdata = cfg_q.coef_e;
      tscv_pkg::REG_COEF_F:  prdata = cfg_q.coef_f;
      tscv_pkg::REG_DIVISOR: prdata = {1'b0, cfg_q.cal_divisor};
      tscv_pkg::REG_GAP:     prdata = {16'd0, cfg_q.sample_gap_ms};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_a <= '0;
      cfg_q.coef_b <= '0;
      cfg_q.coef_c <= '0;
      cfg_q.coef_d <= '0;
      cfg_q.coef_e <= '0;
      cfg_q.coef_f <= '0;
      cfg_q.cal_divisor <= tscv_pkg::DIV_W'(1);
      cfg_q.sample_gap_ms <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> hdl/tscv_lane.sv
// Bit-serial affine sum and signed restoring division for one coordinate.
`timescale 1ns / 1ps
module tscv_lane #(
  parameter int unsigned RAW_BITS = tscv_pkg::RAW_COORD_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [tscv_pkg::COEF_W-1:0]    wx_i,
  input  logic signed [tscv_pkg::COEF_W-1:0]    wy_i,
  input  logic signed [tscv_pkg::COEF_W-1:0]    off_i,
  input  logic [RAW_BITS-1:0]                   rx_i,
  input  logic [RAW_BITS-1:0]                   ry_i,
  input  logic [tscv_pkg::DIV_W-1:0]            div_i,
  output logic                                  done_o,
  output logic [tscv_pkg::COORD_W-1:0]          res_o
);

  localparam int unsigned SUM_W = tscv_pkg::COEF_W + RAW_BITS + 2;
  localparam int unsigned CNT_W = $clog2(SUM_W + 1);

  tscv_pkg::lane_phase_e phase_q, phase_d;
  logic [CNT_W-1:0]                 cnt_q, cnt_d;
  logic                             done_q, done_d;
  logic                             cnt_last;
  logic                             do_start, do_mac, do_off, do_abs, do_div;

  logic signed [SUM_W-1:0]          acc_q;
  logic signed [tscv_pkg::COEF_W-1:0] wx_q, wy_q, off_q;
  logic [RAW_BITS-1:0]              rx_q, ry_q;
  logic [tscv_pkg::DIV_W-1:0]       div_q;
  logic [tscv_pkg::DIV_W-1:0]       rem_q;
  logic [tscv_pkg::COORD_W-1:0]     quo_q;
  logic                             neg_q;
  logic [tscv_pkg::COORD_W-1:0]     res_q;

  logic signed [SUM_W-1:0]          wx_ext, wy_ext, off_ext;
  logic signed [SUM_W-1:0]          mac_sum;
  logic [tscv_pkg::DIV_W:0]         trial, div_ext, diff;
  logic                             ge;
  logic [tscv_pkg::COORD_W-1:0]     quo_next, res_next;

  assign cnt_last = (cnt_q == CNT_W'(1));

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      tscv_pkg::LP_IDLE: if (start_i) phase_d = tscv_pkg::LP_MAC;
      tscv_pkg::LP_MAC:  if (cnt_last) phase_d = tscv_pkg::LP_OFF;
      tscv_pkg::LP_OFF:  phase_d = tscv_pkg::LP_ABS;
      tscv_pkg::LP_ABS:  phase_d = tscv_pkg::LP_DIV;
      tscv_pkg::LP_DIV:  if (cnt_last) phase_d = tscv_pkg::LP_IDLE;
      default:           phase_d = tscv_pkg::LP_IDLE;
    endcase
  end

  always_comb begin
    do_start = 1'b0;
    do_mac = 1'b0;
    do_off = 1'b0;
    do_abs = 1'b0;
    do_div = 1'b0;
    case (phase_q)
      tscv_pkg::LP_IDLE: do_start = start_i;
      tscv_pkg::LP_MAC:  do_mac = 1'b1;
      tscv_pkg::LP_OFF:  do_off = 1'b1;
      tscv_pkg::LP_ABS:  do_abs = 1'b1;
      tscv_pkg::LP_DIV:  do_div = 1'b1;
      default:           do_start = 1'b0;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (do_start) begin
      cnt_d = CNT_W'(RAW_BITS);
    end else if (do_abs) begin
      cnt_d = CNT_W'(SUM_W);
    end else if (do_mac || do_div) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  assign done_d = do_div && cnt_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tscv_pkg::LP_IDLE;
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q <= cnt_d;
      done_q <= done_d;
    end
  end

  assign wx_ext = SUM_W'(wx_q);
  assign wy_ext = SUM_W'(wy_q);
  assign off_ext = SUM_W'(off_q);
  assign mac_sum = (acc_q <<< 1) + (rx_q[RAW_BITS-1] ? wx_ext : '0)
                   + (ry_q[RAW_BITS-1] ? wy_ext : '0);

  assign trial = {rem_q, acc_q[SUM_W-1]};
  assign div_ext = {1'b0, div_q};
  assign ge = (trial >= div_ext);
  assign diff = trial - div_ext;
  assign quo_next = {quo_q[tscv_pkg::COORD_W-2:0], ge};
  assign res_next = neg_q ? (tscv_pkg::COORD_W'(0) - quo_next) : quo_next;

  always_ff @(posedge clk_i) begin
    if (do_start) begin
      acc_q <= '0;
      wx_q <= wx_i;
      wy_q <= wy_i;
      off_q <= off_i;
      rx_q <= rx_i;
      ry_q <= ry_i;
      div_q <= (div_i == '0) ? tscv_pkg::DIV_W'(1) : div_i;
    end else if (do_mac) begin
      acc_q <= mac_sum;
      rx_q <= rx_q << 1;
      ry_q <= ry_q << 1;
    end else if (do_off) begin
      acc_q <= acc_q + off_ext;
    end else if (do_abs) begin
      neg_q <= acc_q[SUM_W-1];
      acc_q <= acc_q[SUM_W-1] ? -acc_q : acc_q;
      rem_q <= '0;
      quo_q <= '0;
    end else if (do_div) begin
      acc_q <= acc_q <<< 1;
      rem_q <= ge ? diff[tscv_pkg::DIV_W-1:0] : trial[tscv_pkg::DIV_W-1:0];
      quo_q <= quo_next;
      if (cnt_last) begin
        res_q <= res_next;
      end
    end
  end

  assign done_o = done_q;
  assign res_o = res_q;

endmodule

>>> dv/touch_sample_calibrate_and_view_step_top_tb.sv
// Self-checking testbench for the touch poll block: it streams polls, writes registers and checks results.
`timescale 1ns / 1ps
module touch_sample_calibrate_and_view_step_top_tb;

  localparam int unsigned RAW_BITS = tscv_pkg::RAW_COORD_BITS_DEF;
  localparam int unsigned TIME_W = tscv_pkg::TIME_W;
  localparam int unsigned COORD_W = tscv_pkg::COORD_W;
  localparam int unsigned VIEW_W = tscv_pkg::VIEW_W;
  localparam int unsigned OUT_DATA_W = tscv_pkg::OUT_DATA_W;
  localparam int unsigned APB_DATA_W = tscv_pkg::APB_DATA_W;
  localparam int unsigned APB_ADDR_W = tscv_pkg::APB_ADDR_W;
  localparam int unsigned REG_IDX_W = tscv_pkg::REG_IDX_W;
  localparam int unsigned COEF_W = tscv_pkg::COEF_W;
  localparam int unsigned POLL_W = ((2 * RAW_BITS + 33 + 7) / 8) * 8;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam logic [APB_DATA_W-1:0] COEF_MIN = 32'h8000_0000;
  localparam logic [APB_DATA_W-1:0] COEF_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [POLL_W-2*RAW_BITS-TIME_W-2:0] fill;
    logic [RAW_BITS-1:0]                 raw_y;
    logic [RAW_BITS-1:0]                 raw_x;
    logic                                panel_touched;
    logic [TIME_W-1:0]                   now_ms;
  } touch_poll_t;

  typedef struct packed {
    logic [OUT_DATA_W-2*COORD_W-VIEW_W-5:0] fill;
    logic [VIEW_W-1:0]                      view_index;
    logic                                   release_edge;
    logic                                   press_edge;
    logic                                   pressed_now;
    logic                                   new_sample;
    logic [COORD_W-1:0]                     display_y;
    logic [COORD_W-1:0]                     display_x;
  } poll_report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;
  logic poll_valid = 1'b0;
  logic poll_ready;
  // now_ms, panel_touched, raw_x, raw_y, zero fill
  touch_poll_t poll_data = '0;
  logic report_valid;
  logic report_ready = 1'b0;
  // display_x, display_y, new_sample, pressed_now, press_edge, release_edge, view_index
  logic [OUT_DATA_W-1:0] report_data;

  tscv_pkg::cfg_t cal_cfg;
  logic [TIME_W-1:0] last_sample_ms;
  logic pressed_state;
  logic [VIEW_W-1:0] view_state;
  logic [COORD_W-1:0] held_x;
  logic [COORD_W-1:0] held_y;
  logic [TIME_W-1:0] poll_clock;
  poll_report_t expected_reports[$];

  bit no_idle = 1'b0;
  int unsigned rx_hold_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned reports_checked = 0;
  int unsigned fresh_samples = 0;
  int unsigned presses = 0;
  int unsigned releases = 0;
  int unsigned settings_used = 0;

  touch_sample_calibrate_and_view_step_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (poll_valid),
    .s_axis_tready_o (poll_ready),
    .s_axis_tdata_i  (poll_data),
    .m_axis_tvalid_o (report_valid),
    .m_axis_tready_i (report_ready),
    .m_axis_tdata_o  (report_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [COORD_W-1:0] calibrate(logic signed [COEF_W-1:0] w_x,
                                                   logic signed [COEF_W-1:0] w_y,
                                                   logic signed [COEF_W-1:0] offset,
                                                   logic [RAW_BITS-1:0] rx,
                                                   logic [RAW_BITS-1:0] ry);
    longint sum;
    longint divisor;
    longint quotient;
    sum = longint'(w_x) * longint'(rx) + longint'(w_y) * longint'(ry) + longint'(offset);
    divisor = longint'(cal_cfg.cal_divisor);
    if (divisor == 0) divisor = 1;
    quotient = sum / divisor;
    return quotient[COORD_W-1:0];
  endfunction

  function automatic poll_report_t advance_poll(touch_poll_t p);
    poll_report_t r;
    logic was_pressed;
    logic [TIME_W-1:0] elapsed;
    r = '0;
    was_pressed = pressed_state;
    elapsed = p.now_ms - last_sample_ms;
    if (elapsed > TIME_W'(cal_cfg.sample_gap_ms)) begin
      pressed_state = p.panel_touched;
      if (p.panel_touched) begin
        held_x = calibrate(cal_cfg.coef_a, cal_cfg.coef_b, cal_cfg.coef_c, p.raw_x, p.raw_y);
        held_y = calibrate(cal_cfg.coef_d, cal_cfg.coef_e, cal_cfg.coef_f, p.raw_x, p.raw_y);
        last_sample_ms = p.now_ms;
        r.new_sample = 1'b1;
      end
    end
    r.press_edge = pressed_state & ~was_pressed;
    r.release_edge = ~pressed_state & was_pressed;
    if (r.release_edge) begin
      case (view_state)
        tscv_pkg::VIEW_STARTUP: view_state = tscv_pkg::VIEW_LOADING;
        tscv_pkg::VIEW_LOADING: view_state = tscv_pkg::VIEW_MAIN;
        tscv_pkg::VIEW_MAIN: view_state = tscv_pkg::VIEW_STARTUP;
        default: ;
      endcase
    end
    r.display_x = held_x;
    r.display_y = held_y;
    r.pressed_now = pressed_state;
    r.view_index = view_state;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic check_report(poll_report_t got);
    poll_report_t want;
    if (expected_reports.size() == 0) begin
      $error("Result transfer %h arrived with no poll outstanding.", got);
      mismatches++;
    end else begin
      want = expected_reports.pop_front();
      check_field("display_x", want.display_x, got.display_x);
      check_field("display_y", want.display_y, got.display_y);
      check_field("new_sample", want.new_sample, got.new_sample);
      check_field("pressed_now", want.pressed_now, got.pressed_now);
      check_field("press_edge", want.press_edge, got.press_edge);
      check_field("release_edge", want.release_edge, got.release_edge);
      check_field("view_index", want.view_index, got.view_index);
      reports_checked++;
      fresh_samples += want.new_sample;
      presses += want.press_edge;
      releases += want.release_edge;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && report_valid && report_ready) check_report(report_data);
  end

  initial begin : report_sink
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_cycles != 0) begin
        report_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        report_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      report_ready <= 1'b1;
      do @(posedge clk_i); while (!report_valid);
    end
  end

  task automatic send_poll(touch_poll_t p);
    int unsigned idle;
    idle = no_idle ? 0 : $urandom_range(0, 9);
    if (idle != 0) begin
      poll_valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    poll_valid <= 1'b1;
    poll_data <= p;
    do @(posedge clk_i); while (!poll_ready);
    expected_reports.push_back(advance_poll(p));
  endtask

  task automatic poll_at(logic [TIME_W-1:0] stamp, logic touched,
                         logic [RAW_BITS-1:0] rx, logic [RAW_BITS-1:0] ry);
    touch_poll_t p;
    p = '0;
    p.now_ms = stamp;
    p.panel_touched = touched;
    p.raw_x = rx;
    p.raw_y = ry;
    poll_clock = stamp;
    send_poll(p);
  endtask

  function automatic logic [RAW_BITS-1:0] random_raw();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return RAW_BITS'($urandom);
    endcase
  endfunction

  // Steps the poll time so that many polls land just inside or just past the gap.
  function automatic logic [TIME_W-1:0] next_poll_time();
    logic [TIME_W-1:0] gap;
    gap = TIME_W'(cal_cfg.sample_gap_ms);
    case ($urandom_range(0, 9))
      0: ;
      1: poll_clock = last_sample_ms + gap;
      2: poll_clock = last_sample_ms + gap + 1;
      3: poll_clock = $urandom;
      4, 5: poll_clock += $urandom_range(0, gap);
      default: poll_clock += gap + 1 + $urandom_range(0, 40);
    endcase
    return poll_clock;
  endfunction

  function automatic touch_poll_t make_poll(logic touched);
    touch_poll_t p;
    p = '0;
    p.now_ms = next_poll_time();
    p.panel_touched = touched;
    p.raw_x = random_raw();
    p.raw_y = random_raw();
    return p;
  endfunction

  // Mostly press-and-lift strokes, with some single polls of random touch state.
  task automatic send_strokes(int unsigned count);
    int unsigned sent;
    int unsigned hold_len;
    int unsigned lift_len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 5) == 0) begin
        send_poll(make_poll($urandom_range(0, 1)));
        sent++;
      end else begin
        hold_len = $urandom_range(1, 6);
        lift_len = $urandom_range(1, 4);
        repeat (hold_len) send_poll(make_poll(1'b1));
        repeat (lift_len) send_poll(make_poll(1'b0));
        sent += hold_len + lift_len;
      end
    end
  endtask

  task automatic wait_reports_drained();
    poll_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      tscv_pkg::REG_COEF_A: cal_cfg.coef_a = value;
      tscv_pkg::REG_COEF_B: cal_cfg.coef_b = value;
      tscv_pkg::REG_COEF_C: cal_cfg.coef_c = value;
      tscv_pkg::REG_COEF_D: cal_cfg.coef_d = value;
      tscv_pkg::REG_COEF_E: cal_cfg.coef_e = value;
      tscv_pkg::REG_COEF_F: cal_cfg.coef_f = value;
      tscv_pkg::REG_DIVISOR: cal_cfg.cal_divisor = value[tscv_pkg::DIV_W-1:0];
      tscv_pkg::REG_GAP: cal_cfg.sample_gap_ms = value[tscv_pkg::GAP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_calibration(logic [APB_DATA_W-1:0] a, logic [APB_DATA_W-1:0] b,
                                     logic [APB_DATA_W-1:0] c, logic [APB_DATA_W-1:0] d,
                                     logic [APB_DATA_W-1:0] e, logic [APB_DATA_W-1:0] f,
                                     logic [APB_DATA_W-1:0] divisor,
                                     logic [APB_DATA_W-1:0] gap);
    wait_reports_drained();
    write_reg(tscv_pkg::REG_COEF_A, a);
    write_reg(tscv_pkg::REG_COEF_B, b);
    write_reg(tscv_pkg::REG_COEF_C, c);
    write_reg(tscv_pkg::REG_COEF_D, d);
    write_reg(tscv_pkg::REG_COEF_E, e);
    write_reg(tscv_pkg::REG_COEF_F, f);
    write_reg(tscv_pkg::REG_DIVISOR, divisor);
    write_reg(tscv_pkg::REG_GAP, gap);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    settings_used++;
  endtask

  task automatic program_random_calibration();
    logic [APB_DATA_W-1:0] w [6];
    logic [APB_DATA_W-1:0] divisor;
    logic [APB_DATA_W-1:0] gap;
    case ($urandom_range(0, 2))
      0: begin
        foreach (w[i]) w[i] = $urandom;
        divisor = $urandom;
      end
      1: begin
        foreach (w[i]) w[i] = APB_DATA_W'($urandom_range(0, 8000)) - 32'd4000;
        w[2] = APB_DATA_W'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
        w[5] = APB_DATA_W'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
        divisor = $urandom_range(1, 4096);
      end
      default: begin
        foreach (w[i]) begin
          w[i] = $urandom_range(0, 1) ? COEF_MIN + $urandom_range(0, 255)
                                      : COEF_MAX - $urandom_range(0, 255);
        end
        divisor = $urandom_range(0, 1) ? COEF_MAX : $urandom_range(1, 16);
      end
    endcase
    gap = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 24);
    program_calibration(w[0], w[1], w[2], w[3], w[4], w[5], divisor, gap);
  endtask

  task automatic test_reset_state();
    poll_at(32'd5, 1'b1, '1, '1);
    poll_at(32'd5, 1'b0, '0, '0);
    poll_at(32'd6, 1'b0, '0, '0);
  endtask

  // Full-scale weights and offsets, the widest gap and the time counter wrapping.
  task automatic test_extreme_coefficients();
    program_calibration(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX,
                        32'd1, 32'hFFFF_FFFF);
    poll_at(32'h0001_0005, 1'b1, '0, '0);
    poll_at(32'h0002_0004, 1'b1, '1, '1);
    poll_at(32'h0002_0005, 1'b1, '1, '0);
    poll_at(32'h0003_0006, 1'b1, '0, '1);
    poll_at(32'h0004_0007, 1'b0, '1, '1);
    poll_at(32'h0004_0008, 1'b1, '1, '1);
    poll_at(32'hFFFF_FF00, 1'b1, 10'd512, 10'd511);
    poll_at(32'h0000_FEFF, 1'b0, '0, '0);
    poll_at(32'h0000_FF00, 1'b0, '0, '0);
  endtask

  // Negative sums truncate toward zero; a divisor of zero behaves as one.
  task automatic test_truncation_and_divisor();
    program_calibration(-32'sd3, 32'sd2, -32'sd5, 32'sd7, -32'sd11, 32'sd13, 32'd7, 32'd0);
    poll_at(32'd100, 1'b1, 10'd1, 10'd0);
    poll_at(32'd101, 1'b1, 10'd3, 10'd1000);
    poll_at(32'd102, 1'b0, 10'd0, 10'd0);
    program_calibration(-32'sd9, 32'sd700, 32'sd1, -32'sd70000, 32'sd3, -32'sd2,
                        32'h8000_0000, 32'd1);
    poll_at(32'd200, 1'b1, 10'd77, 10'd900);
    poll_at(32'd201, 1'b1, 10'd5, 10'd5);
    poll_at(32'd203, 1'b0, 10'd5, 10'd5);
    program_calibration(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MIN,
                        COEF_MAX, 32'd2);
    poll_at(32'd300, 1'b1, '1, '1);
    poll_at(32'd303, 1'b0, '1, '1);
  endtask

  task automatic test_random_strokes();
    repeat (5) begin
      program_random_calibration();
      send_strokes(65);
      wait_reports_drained();
      send_strokes(65);
    end
  endtask

  task automatic test_back_to_back();
    program_random_calibration();
    no_idle = 1'b1;
    send_strokes(100);
    no_idle = 1'b0;
  endtask

  task automatic test_output_backpressure();
    program_random_calibration();
    no_idle = 1'b1;
    rx_hold_cycles = 400;
    send_strokes(40);
    no_idle = 1'b0;
    wait_reports_drained();
    send_strokes(20);
  endtask

  initial begin : test_sequence
    int unsigned drain_cycles;
    cal_cfg = '0;
    cal_cfg.cal_divisor = 1;
    last_sample_ms = '0;
    pressed_state = 1'b0;
    view_state = tscv_pkg::VIEW_STARTUP;
    held_x = '0;
    held_y = '0;
    poll_clock = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_extreme_coefficients();
    test_truncation_and_divisor();
    test_random_strokes();
    test_back_to_back();
    test_output_backpressure();
    poll_valid <= 1'b0;
    drain_cycles = 0;
    while (expected_reports.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    if (expected_reports.size() != 0) begin
      $error("%0d poll results never arrived.", expected_reports.size());
      $display("FAILURE");
    end else begin
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      $display("Checked %0d poll results with %0d fresh samples, %0d presses, %0d releases.",
               reports_checked, fresh_samples, presses, releases);
      $display("Ran %0d calibration settings with output stalls, bursts and time wrap.",
               settings_used);
      if (mismatches == 0) begin
        $display("SUCCESS");
      end else begin
        $display("FAILURE");
      end
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $error("Run did not finish in time.");
    $display("FAILURE");
    $finish;
  end

endmodule

>>> sim.f
hdl/tscv_pkg.sv
hdl/tscv_regs.sv
hdl/tscv_lane.sv
hdl/touch_sample_calibrate_and_view_step_top.sv
dv/touch_sample_calibrate_and_view_step_top_tb.sv
